// ----- src/differential_drive_odometry_top_defines.svh -----
// assertion macros used by the checker
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_DEFINES_SVH

// condition in the cycle after a trigger, ignored during reset
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odometry check failed");

// condition in the cycle after reset
`define DDO_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("odometry reset check failed");

`endif

// ----- src/ddo_pkg.sv -----
package ddo_pkg;

   // register indexes
   localparam logic [1:0] REG_DIAMETER = 2'd0;
   localparam logic [1:0] REG_TRACK    = 2'd1;

   // fixed point constants
   localparam logic [29:0] PI_Q28     = 30'd843314857;
   localparam logic [34:0] PI_Q28_X25 = 35'd21082871425;
   localparam logic [29:0] GAIN_Q30   = 30'd652032875;
   localparam logic [24:0] FULL_TURN  = 25'd23592960;
   localparam logic [24:0] HALF_TURN  = 25'd11796480;
   localparam logic [24:0] QUARTER_TURN = 25'd5898240;
   localparam logic [20:0] STR_DEN    = 21'd1474560;
   localparam logic [20:0] STR_HALF   = 21'd737280;
   localparam logic [9:0]  CHORD_K    = 10'd783;

   typedef struct packed {
      logic signed [11:0] left_step_deg;
      logic signed [11:0] right_step_deg;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading_deg;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  index;
      logic [11:0] value;
   } csr_type;

   // shared multiply / divide unit
   typedef struct packed {
      logic        start;
      logic        div;
      logic [63:0] opa;
      logic [35:0] opb;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] prod;
      logic [57:0] quot;
      logic [27:0] rem;
   } md_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_MUL,
      ST_TURN_DIV,
      ST_TEST_MUL,
      ST_RS_MUL,
      ST_RSPI_MUL,
      ST_STR_DIV,
      ST_CH_MOD,
      ST_CH_CORDIC,
      ST_TS_MUL,
      ST_TSN_MUL,
      ST_CH_DIV,
      ST_GAIN_MUL,
      ST_POS_MOD,
      ST_POS_CORDIC,
      ST_UPDATE
   } state_type;

   // arctangent of 2^-i in degrees q16.16
   function automatic logic [21:0] atan_deg(input logic [4:0] i);
      logic [21:0] a;
      case (i)
         5'd0:  a = 22'd2949120;
         5'd1:  a = 22'd1740967;
         5'd2:  a = 22'd919879;
         5'd3:  a = 22'd466945;
         5'd4:  a = 22'd234379;
         5'd5:  a = 22'd117304;
         5'd6:  a = 22'd58666;
         5'd7:  a = 22'd29335;
         5'd8:  a = 22'd14668;
         5'd9:  a = 22'd7334;
         5'd10: a = 22'd3667;
         5'd11: a = 22'd1833;
         5'd12: a = 22'd917;
         5'd13: a = 22'd458;
         5'd14: a = 22'd229;
         5'd15: a = 22'd115;
         5'd16: a = 22'd57;
         5'd17: a = 22'd29;
         5'd18: a = 22'd14;
         5'd19: a = 22'd7;
         5'd20: a = 22'd4;
         5'd21: a = 22'd2;
         5'd22: a = 22'd1;
         default: a = 22'd0;
      endcase
      return a;
   endfunction

   // clamp to the 32 bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      logic signed [31:0] r;
      if (v > 42'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -42'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- src/ddo_stream_if.sv -----
interface ddo_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- src/ddo_muldiv.sv -----
module ddo_muldiv (
   input  logic                clock,
   input  logic                reset,
   input  ddo_pkg::md_req_type req,
   output ddo_pkg::md_rsp_type rsp
);

   logic        busy_ff, div_ff, done_ff;
   logic [63:0] mc_ff, acc_ff;
   logic [35:0] mp_ff;
   logic [5:0]  cnt_ff;

   logic [28:0] rem_sh;
   logic [29:0] diff;
   logic        ge;
   logic        last_step;

   // one restoring division step
   always_comb begin
      rem_sh    = {acc_ff[27:0], mc_ff[57]};
      diff      = {1'b0, rem_sh} - {2'b00, mp_ff[27:0]};
      ge        = !diff[29];
      last_step = div_ff ? (cnt_ff == 6'd57) : (mp_ff == 36'd0);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
      end else begin
         done_ff <= busy_ff && !req.start && last_step;
         if (req.start) begin
            busy_ff <= 1'b1;
            div_ff  <= req.div;
         end else if (busy_ff && last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // datapath: shift-add multiply or one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (req.start) begin
         mc_ff  <= req.div ? {6'd0, req.opa[57:0]} : req.opa;
         mp_ff  <= req.opb;
         acc_ff <= 64'd0;
         cnt_ff <= 6'd0;
      end else if (busy_ff) begin
         if (div_ff) begin
            acc_ff <= {36'd0, (ge ? diff[27:0] : rem_sh[27:0])};
            mc_ff  <= {6'd0, mc_ff[56:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
         end else if (mp_ff != 36'd0) begin
            if (mp_ff[0]) begin
               acc_ff <= acc_ff + mc_ff;
            end
            mc_ff <= {mc_ff[62:0], 1'b0};
            mp_ff <= {1'b0, mp_ff[35:1]};
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;
   assign rsp.quot = mc_ff[57:0];
   assign rsp.rem  = acc_ff[27:0];

endmodule

// ----- src/differential_drive_odometry_top.sv -----
// each item runs a chain of steps on the shared serial multiply / divide unit
// (one multiplier bit or one quotient bit per cycle) and the cordic steps; a spin in
// place takes the fewest steps, the chord path the most
// throughput: one item in flight; the next item is taken once the result sits in
// the output register
// reset: synchronous, clears the pose, loads diameter 100 and track 126
module differential_drive_odometry_top #(
   parameter int TRIG_ITERATIONS = 16
) (
   input logic          clock,
   input logic          reset,
   ddo_stream_if.sink   req_ch,
   ddo_stream_if.source rsp_ch,
   ddo_stream_if.sink   csr_ch
);

   localparam int ITW = $clog2(TRIG_ITERATIONS);

   ddo_pkg::state_type  state_ff, state_in;
   logic                go_ff, go_in;
   ddo_pkg::md_req_type md_req;
   ddo_pkg::md_rsp_type md_rsp;

   logic [9:0]         diam_ff;
   logic [11:0]        trk_ff;
   logic signed [11:0] dl_ff, dr_ff;
   logic [20:0]        rd_ff;
   logic signed [39:0] turn_ff, travel_ff, x0_ff, cx_ff, cy_ff;
   logic signed [27:0] cz_ff;
   logic               neg_ff;
   logic [ITW-1:0]     it_ff;
   logic signed [31:0] pose_x_ff, pose_y_ff, pose_h_ff;
   ddo_pkg::rsp_type   out_ff;
   logic               out_valid_ff;

   logic [8:0]         r_w;
   logic [11:0]        trk_w;
   logic signed [12:0] s_w, d_w;
   logic [12:0]        as_w, ad_w;
   logic               spin_w, chord_w, cordic_last, out_free, req_take;
   logic [39:0]        tmag_w, hmag_w, q_w, sn_mag, tr_mag;
   logic signed [39:0] half_w, sn_w, cx_fin, turn_new, travel_new;
   logic signed [40:0] ang_w;
   logic [40:0]        ang_mag;
   logic [24:0]        rem_w, z0_w;
   logic signed [26:0] z1_w;
   logic signed [27:0] zf_w;
   logic               negf_w;
   logic [64:0]        gsum_w;
   logic signed [39:0] x0_new;
   logic signed [39:0] xs_w, ys_w;
   logic [21:0]        atan_w;
   logic [39:0]        cxm_w, cym_w;
   logic [31:0]        rndx_w, rndy_w;
   logic signed [41:0] sumx_w, sumy_w, sumh_w;
   logic signed [31:0] nx_w, ny_w, nh_w;
   logic [31:0]        kt_w;

   function automatic logic [21:0] CHORD_K_X(input logic [11:0] t);
      return 22'(ddo_pkg::CHORD_K) * 22'(t);
   endfunction

   // shared serial arithmetic
   ddo_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   // step decode
   always_comb begin
      r_w    = diam_ff[9:1];
      trk_w  = (trk_ff == 12'd0) ? 12'd1 : trk_ff;
      s_w    = {dl_ff[11], dl_ff} + {dr_ff[11], dr_ff};
      d_w    = {dl_ff[11], dl_ff} - {dr_ff[11], dr_ff};
      as_w   = s_w[12] ? (13'd0 - $unsigned(s_w)) : $unsigned(s_w);
      ad_w   = d_w[12] ? (13'd0 - $unsigned(d_w)) : $unsigned(d_w);
      spin_w = (r_w != 9'd0) &&
               ((dl_ff > 12'sd0 && dr_ff < 12'sd0) || (dl_ff < 12'sd0 && dr_ff > 12'sd0));
   end

   // half turn, rounded away from zero
   always_comb begin
      tmag_w = turn_ff[39] ? (40'd0 - $unsigned(turn_ff)) : $unsigned(turn_ff);
      hmag_w = (tmag_w + 40'd1) >> 1;
      half_w = turn_ff[39] ? $signed(40'd0 - hmag_w) : $signed(hmag_w);
   end

   // rotation angle and cordic outputs
   always_comb begin
      if (state_ff == ddo_pkg::ST_CH_MOD) begin
         ang_w = {half_w[39], half_w};
      end else begin
         ang_w = {{9{pose_h_ff[31]}}, pose_h_ff} + {half_w[39], half_w};
      end
      ang_mag = ang_w[40] ? (41'd0 - $unsigned(ang_w)) : $unsigned(ang_w);
      sn_w    = neg_ff ? -cy_ff : cy_ff;
      cx_fin  = neg_ff ? -cx_ff : cx_ff;
      sn_mag  = sn_w[39] ? (40'd0 - $unsigned(sn_w)) : $unsigned(sn_w);
      tr_mag  = travel_ff[39] ? (40'd0 - $unsigned(travel_ff)) : $unsigned(travel_ff);
   end

   // quotient with sign, chord test
   always_comb begin
      q_w  = md_rsp.quot[39:0];
      kt_w = 32'(CHORD_K_X(trk_w));
      chord_w = md_rsp.prod > 64'({kt_w, 28'd0});
      turn_new = (d_w[12] ^ spin_w) ? $signed(40'd0 - q_w) : $signed(q_w);
      if (state_ff == ddo_pkg::ST_CH_DIV) begin
         travel_new = (s_w[12] ^ sn_w[39] ^ d_w[12]) ? $signed(40'd0 - q_w) : $signed(q_w);
      end else begin
         travel_new = s_w[12] ? $signed(40'd0 - q_w) : $signed(q_w);
      end
   end

   // angle reduction to [-90, 90] with a sign flip
   always_comb begin
      rem_w  = md_rsp.rem[24:0];
      z0_w   = (ang_w[40] && rem_w != 25'd0) ? (ddo_pkg::FULL_TURN - rem_w) : rem_w;
      z1_w   = (z0_w >= ddo_pkg::HALF_TURN) ?
               ($signed({2'b00, z0_w}) - $signed({2'b00, ddo_pkg::FULL_TURN})) :
               $signed({2'b00, z0_w});
      negf_w = 1'b0;
      zf_w   = {z1_w[26], z1_w};
      if (z1_w > $signed({2'b00, ddo_pkg::QUARTER_TURN})) begin
         zf_w   = {z1_w[26], z1_w} - $signed({3'b000, ddo_pkg::HALF_TURN});
         negf_w = 1'b1;
      end else if (z1_w < -$signed({2'b00, ddo_pkg::QUARTER_TURN})) begin
         zf_w   = {z1_w[26], z1_w} + $signed({3'b000, ddo_pkg::HALF_TURN});
         negf_w = 1'b1;
      end
   end

   // travel times gain, floor shift by 30
   always_comb begin
      gsum_w = {1'b0, md_rsp.prod} + 65'h3fffffff;
      if (travel_ff[39]) begin
         x0_new = $signed(40'd0 - 40'(gsum_w[64:30]));
      end else begin
         x0_new = $signed(40'(md_rsp.prod[63:30]));
      end
   end

   // one cordic rotation
   always_comb begin
      xs_w   = cx_ff >>> it_ff;
      ys_w   = cy_ff >>> it_ff;
      atan_w = ddo_pkg::atan_deg(5'(it_ff));
      cordic_last = (it_ff == ITW'(TRIG_ITERATIONS - 1));
   end

   // new pose
   always_comb begin
      cxm_w  = cx_fin[39] ? (40'd0 - $unsigned(cx_fin)) : $unsigned(cx_fin);
      cym_w  = sn_w[39] ? (40'd0 - $unsigned(sn_w)) : $unsigned(sn_w);
      rndx_w = 32'((cxm_w + 40'd128) >> 8);
      rndy_w = 32'((cym_w + 40'd128) >> 8);
      sumx_w = {{10{pose_x_ff[31]}}, pose_x_ff} +
               (cx_fin[39] ? -$signed({10'd0, rndx_w}) : $signed({10'd0, rndx_w}));
      sumy_w = {{10{pose_y_ff[31]}}, pose_y_ff} +
               (sn_w[39] ? -$signed({10'd0, rndy_w}) : $signed({10'd0, rndy_w}));
      sumh_w = {{10{pose_h_ff[31]}}, pose_h_ff} + {{2{turn_ff[39]}}, turn_ff};
      nx_w   = (travel_ff != 40'sd0) ? ddo_pkg::sat32(sumx_w) : pose_x_ff;
      ny_w   = (travel_ff != 40'sd0) ? ddo_pkg::sat32(sumy_w) : pose_y_ff;
      nh_w   = ddo_pkg::sat32(sumh_w);
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign req_take = req_ch.valid && req_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ddo_pkg::ST_IDLE:       if (req_take) state_in = ddo_pkg::ST_RD_MUL;
         ddo_pkg::ST_RD_MUL:     if (md_rsp.done) state_in = ddo_pkg::ST_TURN_DIV;
         ddo_pkg::ST_TURN_DIV: begin
            if (md_rsp.done) state_in = spin_w ? ddo_pkg::ST_UPDATE : ddo_pkg::ST_TEST_MUL;
         end
         ddo_pkg::ST_TEST_MUL: begin
            if (md_rsp.done) state_in = chord_w ? ddo_pkg::ST_CH_MOD : ddo_pkg::ST_RS_MUL;
         end
         ddo_pkg::ST_RS_MUL:     if (md_rsp.done) state_in = ddo_pkg::ST_RSPI_MUL;
         ddo_pkg::ST_RSPI_MUL:   if (md_rsp.done) state_in = ddo_pkg::ST_STR_DIV;
         ddo_pkg::ST_STR_DIV, ddo_pkg::ST_CH_DIV: begin
            if (md_rsp.done) begin
               state_in = (travel_new != 40'sd0) ? ddo_pkg::ST_GAIN_MUL : ddo_pkg::ST_UPDATE;
            end
         end
         ddo_pkg::ST_CH_MOD:     if (md_rsp.done) state_in = ddo_pkg::ST_CH_CORDIC;
         ddo_pkg::ST_CH_CORDIC:  if (cordic_last) state_in = ddo_pkg::ST_TS_MUL;
         ddo_pkg::ST_TS_MUL:     if (md_rsp.done) state_in = ddo_pkg::ST_TSN_MUL;
         ddo_pkg::ST_TSN_MUL:    if (md_rsp.done) state_in = ddo_pkg::ST_CH_DIV;
         ddo_pkg::ST_GAIN_MUL:   if (md_rsp.done) state_in = ddo_pkg::ST_POS_MOD;
         ddo_pkg::ST_POS_MOD:    if (md_rsp.done) state_in = ddo_pkg::ST_POS_CORDIC;
         ddo_pkg::ST_POS_CORDIC: if (cordic_last) state_in = ddo_pkg::ST_UPDATE;
         ddo_pkg::ST_UPDATE:     if (out_free) state_in = ddo_pkg::ST_IDLE;
         default:                state_in = ddo_pkg::ST_IDLE;
      endcase
   end

   // start pulse on entry to a state that uses the arithmetic unit
   always_comb begin
      case (state_in)
         ddo_pkg::ST_IDLE, ddo_pkg::ST_CH_CORDIC, ddo_pkg::ST_POS_CORDIC,
         ddo_pkg::ST_UPDATE: go_in = 1'b0;
         default:            go_in = (state_in != state_ff);
      endcase
   end

   // outputs: handshakes and arithmetic operands
   always_comb begin
      req_ch.ready = (state_ff == ddo_pkg::ST_IDLE);
      csr_ch.ready = 1'b1;
      md_req.start = go_ff;
      md_req.div   = 1'b0;
      md_req.opa   = 64'd0;
      md_req.opb   = 36'd0;
      case (state_ff)
         ddo_pkg::ST_RD_MUL: begin
            md_req.opa = 64'(ad_w);
            md_req.opb = 36'(r_w);
         end
         ddo_pkg::ST_TURN_DIV: begin
            md_req.div = 1'b1;
            md_req.opa = 64'({rd_ff, 16'd0}) + 64'(trk_w[11:1]);
            md_req.opb = 36'(trk_w);
         end
         ddo_pkg::ST_TEST_MUL: begin
            md_req.opa = 64'(ddo_pkg::PI_Q28_X25);
            md_req.opb = 36'(rd_ff);
         end
         ddo_pkg::ST_RS_MUL: begin
            md_req.opa = 64'(as_w);
            md_req.opb = 36'(r_w);
         end
         ddo_pkg::ST_RSPI_MUL: begin
            md_req.opa = 64'(ddo_pkg::PI_Q28);
            md_req.opb = 36'(md_rsp.prod[20:0]);
         end
         ddo_pkg::ST_STR_DIV: begin
            md_req.div = 1'b1;
            md_req.opa = md_rsp.prod + 64'(ddo_pkg::STR_HALF);
            md_req.opb = 36'(ddo_pkg::STR_DEN);
         end
         ddo_pkg::ST_CH_MOD, ddo_pkg::ST_POS_MOD: begin
            md_req.div = 1'b1;
            md_req.opa = 64'(ang_mag);
            md_req.opb = 36'(ddo_pkg::FULL_TURN);
         end
         ddo_pkg::ST_TS_MUL: begin
            md_req.opa = 64'(as_w);
            md_req.opb = 36'(trk_w);
         end
         ddo_pkg::ST_TSN_MUL: begin
            md_req.opa = 64'(sn_mag);
            md_req.opb = 36'(md_rsp.prod[24:0]);
         end
         ddo_pkg::ST_CH_DIV: begin
            md_req.div = 1'b1;
            md_req.opa = md_rsp.prod + 64'({ad_w, 13'd0});
            md_req.opb = 36'({ad_w, 14'd0});
         end
         ddo_pkg::ST_GAIN_MUL: begin
            md_req.opa = 64'(tr_mag);
            md_req.opb = 36'(ddo_pkg::GAIN_Q30);
         end
         default: begin
            md_req.div = 1'b0;
         end
      endcase
   end

   // control state, configuration, pose and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddo_pkg::ST_IDLE;
         go_ff        <= 1'b0;
         diam_ff      <= 10'd100;
         trk_ff       <= 12'd126;
         pose_x_ff    <= 32'sd0;
         pose_y_ff    <= 32'sd0;
         pose_h_ff    <= 32'sd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff    <= go_in;
         if (csr_ch.valid) begin
            case (csr_ch.payload.index)
               ddo_pkg::REG_DIAMETER: diam_ff <= csr_ch.payload.value[9:0];
               ddo_pkg::REG_TRACK:    trk_ff  <= csr_ch.payload.value;
               default:               diam_ff <= diam_ff;
            endcase
         end
         if (state_ff == ddo_pkg::ST_UPDATE && out_free) begin
            pose_x_ff    <= nx_w;
            pose_y_ff    <= ny_w;
            pose_h_ff    <= nh_w;
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         dl_ff     <= req_ch.payload.left_step_deg;
         dr_ff     <= req_ch.payload.right_step_deg;
         travel_ff <= 40'sd0;
      end
      if (state_ff == ddo_pkg::ST_RD_MUL && md_rsp.done) begin
         rd_ff <= md_rsp.prod[20:0];
      end
      if (state_ff == ddo_pkg::ST_TURN_DIV && md_rsp.done) begin
         turn_ff <= turn_new;
      end
      if ((state_ff == ddo_pkg::ST_STR_DIV || state_ff == ddo_pkg::ST_CH_DIV) &&
          md_rsp.done) begin
         travel_ff <= travel_new;
      end
      if (state_ff == ddo_pkg::ST_GAIN_MUL && md_rsp.done) begin
         x0_ff <= x0_new;
      end
      // cordic load after angle reduction
      if ((state_ff == ddo_pkg::ST_CH_MOD || state_ff == ddo_pkg::ST_POS_MOD) &&
          md_rsp.done) begin
         cx_ff  <= (state_ff == ddo_pkg::ST_CH_MOD) ? 40'(ddo_pkg::GAIN_Q30) : x0_ff;
         cy_ff  <= 40'sd0;
         cz_ff  <= zf_w;
         neg_ff <= negf_w;
         it_ff  <= '0;
      end
      // cordic rotation step
      if (state_ff == ddo_pkg::ST_CH_CORDIC || state_ff == ddo_pkg::ST_POS_CORDIC) begin
         if (!cz_ff[27]) begin
            cx_ff <= cx_ff - ys_w;
            cy_ff <= cy_ff + xs_w;
            cz_ff <= cz_ff - $signed({6'd0, atan_w});
         end else begin
            cx_ff <= cx_ff + ys_w;
            cy_ff <= cy_ff - xs_w;
            cz_ff <= cz_ff + $signed({6'd0, atan_w});
         end
         it_ff <= it_ff + ITW'(1);
      end
      if (state_ff == ddo_pkg::ST_UPDATE && out_free) begin
         out_ff.pos_x       <= nx_w;
         out_ff.pos_y       <= ny_w;
         out_ff.heading_deg <= nh_w;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_ff;

endmodule

// ----- src/ddo_checker.sv -----
`include "differential_drive_odometry_top_defines.svh"

module ddo_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ddo_pkg::rsp_type rsp_payload
);

   // a stalled result holds
   `DDO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // one item in flight: no second item right after one is taken
   `DDO_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)

   // idle and empty after reset
   `DDO_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready)

endmodule

bind differential_drive_odometry_top ddo_checker u_ddo_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
